### rtl/sha1bs_pkg.sv
package sha1bs_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // round function group, one per twenty rounds
  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } grp_t;

  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned WIN_DEPTH = 16;

  localparam logic [6:0] RND_LAST  = 7'd79;
  localparam logic [6:0] RND_SCHED = 7'd16;
  localparam logic [6:0] RND_G1    = 7'd20;
  localparam logic [6:0] RND_G2    = 7'd40;
  localparam logic [6:0] RND_G3    = 7'd60;

  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [2:0] IDX_LAST = 3'd4;

  localparam word_t IV [NUM_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  function automatic word_t round_k(grp_t g);
    word_t k;
    case (g)
      GRP_CH:   k = 32'h5a827999;
      GRP_PAR1: k = 32'h6ed9eba1;
      GRP_MAJ:  k = 32'h8f1bbcdc;
      default:  k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       word_push;
    logic       load;
    logic       round_en;
    logic       sched_upd;
    grp_t       grp;
    logic       add_en;
  } ctl_t;

endpackage

### rtl/sha1bs_ctrl.sv
module sha1bs_ctrl import sha1bs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [2:0] m_tuser,
  output logic       m_tlast,
  output ctl_t       ctl
);

  state_t      state;
  state_t      state_next;
  state_t      ret;
  state_t      ret_next;
  logic [5:0]  pos;
  logic [63:0] bit_count;
  logic [6:0]  rnd;
  logic [2:0]  idx;
  logic [7:0]  len_byte;
  grp_t        grp;

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser && pos == POS_LAST) begin
            state_next = ST_ROUND;
            ret_next   = s_tlast ? ST_MARK : ST_IDLE;
          end else if (s_tlast) begin
            state_next = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        if (pos == POS_LAST) begin
          state_next = ST_ROUND;
          ret_next   = ST_ZERO;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (pos == POS_LEN) begin
          state_next = ST_LEN;
        end else if (pos == POS_LAST) begin
          state_next = ST_ROUND;
          ret_next   = ST_ZERO;
        end
      end
      ST_LEN: begin
        if (pos == POS_LAST) begin
          state_next = ST_ROUND;
          ret_next   = ST_OUT;
        end
      end
      ST_ROUND: begin
        if (rnd == RND_LAST) state_next = ST_ADD;
      end
      ST_ADD: begin
        state_next = ret;
      end
      ST_OUT: begin
        if (m_tready && idx == IDX_LAST) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (rnd < RND_G1) grp = GRP_CH;
    else if (rnd < RND_G2) grp = GRP_PAR1;
    else if (rnd < RND_G3) grp = GRP_MAJ;
    else grp = GRP_PAR2;
  end

  // length field goes out most significant byte first
  assign len_byte = 8'(bit_count >> {~pos[2:0], 3'b000});

  // outputs
  always_comb begin
    ctl      = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready     = 1'b1;
        ctl.byte_en  = s_tvalid && s_tuser;
        ctl.byte_val = s_tdata;
      end
      ST_MARK: begin
        ctl.byte_en  = 1'b1;
        ctl.byte_val = PAD_MARK;
      end
      ST_ZERO: begin
        ctl.byte_en = (pos != POS_LEN);
      end
      ST_LEN: begin
        ctl.byte_en  = 1'b1;
        ctl.byte_val = len_byte;
      end
      ST_ROUND: begin
        ctl.round_en  = 1'b1;
        ctl.sched_upd = (rnd >= RND_SCHED);
        ctl.grp       = grp;
      end
      ST_ADD: begin
        ctl.add_en = 1'b1;
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
      end
      default: ;
    endcase
    ctl.word_push = ctl.byte_en && (pos[1:0] == 2'b11);
    ctl.load      = ctl.byte_en && (pos == POS_LAST);
  end

  assign m_tuser = idx;
  assign m_tlast = (idx == IDX_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      pos       <= '0;
      bit_count <= '0;
      rnd       <= '0;
      idx       <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (ctl.byte_en) pos <= pos + 6'd1;
      if (ctl.load) rnd <= '0;
      else if (ctl.round_en) rnd <= rnd + 7'd1;
      if (m_tvalid && m_tready) begin
        if (idx == IDX_LAST) begin
          idx       <= '0;
          bit_count <= '0;
        end else begin
          idx <= idx + 3'd1;
        end
      end else if (state == ST_IDLE && ctl.byte_en) begin
        bit_count <= bit_count + 64'd8;
      end
    end
  end

endmodule

### rtl/sha1bs_sched.sv
module sha1bs_sched import sha1bs_pkg::*; (
  input  logic  clk,
  input  ctl_t  ctl,
  output word_t w
);

  word_t       win [WIN_DEPTH];
  logic [23:0] acc;
  word_t       mix;
  word_t       push_word;

  // oldest word sits in win[0]
  assign mix       = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w         = ctl.sched_upd ? {mix[30:0], mix[31]} : win[0];
  assign push_word = ctl.round_en ? w : {acc, ctl.byte_val};

  always_ff @(posedge clk) begin
    if (ctl.byte_en && !ctl.word_push) acc <= {acc[15:0], ctl.byte_val};
    if (ctl.word_push || ctl.round_en) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] <= win[i + 1];
      win[WIN_DEPTH - 1] <= push_word;
    end
  end

endmodule

### rtl/sha1bs_round.sv
module sha1bs_round import sha1bs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl,
  input  word_t w,
  input  word_t chain [NUM_WORDS],
  output word_t vars  [NUM_WORDS]
);

  word_t f;
  word_t tmp;

  always_comb begin
    case (ctl.grp)
      GRP_CH:  f = (vars[1] & vars[2]) | (~vars[1] & vars[3]);
      GRP_MAJ: f = (vars[1] & vars[2]) | (vars[1] & vars[3]) | (vars[2] & vars[3]);
      default: f = vars[1] ^ vars[2] ^ vars[3];
    endcase
  end

  assign tmp = {vars[0][26:0], vars[0][31:27]} + f + vars[4] + w + round_k(ctl.grp);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) vars[i] <= '0;
    end else if (ctl.load) begin
      for (int i = 0; i < NUM_WORDS; i++) vars[i] <= chain[i];
    end else if (ctl.round_en) begin
      vars[4] <= vars[3];
      vars[3] <= vars[2];
      vars[2] <= {vars[1][1:0], vars[1][31:2]};
      vars[1] <= vars[0];
      vars[0] <= tmp;
    end
  end

endmodule

### rtl/sha1_byte_stream_hasher_core.sv
// channel  dir  tdata               tuser              tlast
// s_*      in   data_byte [7:0]     byte_present       message_end
// m_*      out  digest_word [31:0]  word_index [2:0]   digest_last
//
// a byte that fills a 64-byte block starts a compression (80 rounds on the
// single round unit, then the chaining add); the load of the working variables
// rides on the byte's own cycle
// the end marker starts byte-serial padding, one pad byte a cycle up to the
// length field except while a filled block is compressed, then one or two
// compressions and five digest words; s_tready is low from a block's last byte
// until its compression is done, through padding and while digest words wait
// on m_tready; synchronous active-high reset, no clearing pass
module sha1_byte_stream_hasher_core import sha1bs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // byte_present
  input  logic        s_tlast,   // message_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // digest_word
  output logic [2:0]  m_tuser,   // word_index
  output logic        m_tlast    // digest_last
);

  ctl_t  ctl;
  word_t w;
  word_t chain [NUM_WORDS];
  word_t vars  [NUM_WORDS];

  // sequencer: byte position, bit length, round count, padding and output order
  sha1bs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .ctl      (ctl)
  );

  // block buffer doubling as the rolling message schedule
  sha1bs_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w   (w)
  );

  // the shared round unit with working variables a..e
  sha1bs_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .w     (w),
    .chain (chain),
    .vars  (vars)
  );

  // chaining value; rotated by one word per digest word sent, so the
  // word on offer is always chain[0]
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) chain[i] <= IV[i];
    end else if (ctl.add_en) begin
      for (int i = 0; i < NUM_WORDS; i++) chain[i] <= chain[i] + vars[i];
    end else if (m_tvalid && m_tready) begin
      if (m_tlast) begin
        // fresh initial vector for the next message
        for (int i = 0; i < NUM_WORDS; i++) chain[i] <= IV[i];
      end else begin
        for (int i = 0; i < NUM_WORDS - 1; i++) chain[i] <= chain[i + 1];
        chain[NUM_WORDS - 1] <= chain[0];
      end
    end
  end

  assign m_tdata = chain[0];

endmodule

### rtl/sha1bs_check.sv
module sha1bs_check import sha1bs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed under stall");

  // no input is taken while the digest is being sent
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while digest pending");

  // the last flag marks the fifth word only
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == IDX_LAST)))
    else $error("digest last flag out of place");

  // digest words follow one another in order
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
    else $error("digest word index skipped");

  // after the final word the block takes input again
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("block not idle after digest");

endmodule

bind sha1_byte_stream_hasher_core sha1bs_check u_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### test/sha1_byte_stream_hasher_core_tb.sv
module sha1_byte_stream_hasher_core_tb import sha1bs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // watchdog limit, well over the slowest correct run
  localparam int unsigned LIMIT_CYCLES    = 400000;
  // extra wait once no digest word is outstanding
  localparam int unsigned DRAIN_CYCLES    = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 800;
  localparam int unsigned RAND_BYTES      = 200;
  localparam int unsigned SCRIPT_ROWS     = 18;

  localparam word_t K_CH   = 32'h5a827999;
  localparam word_t K_PAR1 = 32'h6ed9eba1;
  localparam word_t K_MAJ  = 32'h8f1bbcdc;
  localparam word_t K_PAR2 = 32'hca62c1d6;

  // well-known digests of the empty message and of "abc"
  localparam logic [159:0] DIGEST_EMPTY =
    160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] DIGEST_ABC =
    160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  // one row of the directed script; digest is typed in only where known is set
  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         last_flag;
    logic         known;
    logic [159:0] digest;
  } script_row_t;

  // one digest word as it should leave the block
  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       last_flag;
  } digest_word_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // data_byte
  logic        s_tuser  = 1'b0; // byte_present
  logic        s_tlast  = 1'b0; // message_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // digest_word
  logic [2:0]  m_tuser;         // word_index
  logic        m_tlast;         // digest_last

  // hashing state of the predictor
  word_t       hash_state [NUM_WORDS];
  word_t       block_buf [16];
  logic [63:0] bit_total;

  digest_word_t digest_words_due [$];
  int unsigned  mismatches    = 0;
  int unsigned  cycle_count   = 0;
  bit           steady        = 1'b0;  // no random gaps on either side while set
  bit           hold_off_due  = 1'b0;
  bit           hold_off_done = 1'b0;

  // directed script: empty messages, end with and without a byte, stray data
  // on steps with no byte, byte extremes, back-to-back messages
  script_row_t script [SCRIPT_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},  // empty message straight after reset
    '{8'ha5, 1'b0, 1'b0, 1'b0, 160'h0},        // empty step, data ignored
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},    // last byte carries the end flag
    '{8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h5a, 1'b0, 1'b1, 1'b0, 160'h0},        // end alone, stray data
    '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'hc3, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h01, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hfe, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h55, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'haa, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h3c, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY}   // chaining value back at the iv
  };

  sha1_byte_stream_hasher_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly back to back, often a short gap, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // big-endian byte placement; the first byte of a word clears the word
  function automatic void stash_byte(int unsigned pos, logic [7:0] b);
    int unsigned wi;
    wi = pos / 4;
    if (pos % 4 == 0) block_buf[wi] = '0;
    block_buf[wi][8 * (3 - pos % 4) +: 8] = b;
  endfunction

  // 80 rounds over the block buffer, schedule rolled in place, then chaining add
  function automatic void run_rounds();
    word_t a, b, c, d, e, f, k, sw, t;
    int unsigned s;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16) begin
        sw = block_buf[(s + 13) % 16] ^ block_buf[(s + 8) % 16] ^
             block_buf[(s + 2) % 16] ^ block_buf[s];
        sw = {sw[30:0], sw[31]};
        block_buf[s] = sw;
      end else begin
        sw = block_buf[s];
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PAR1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_PAR2;
      end
      t = {a[26:0], a[31:27]} + f + e + sw + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  // takes one accepted word; returns 1 with the digest when the message ends
  function automatic bit absorb_word(logic [7:0] data, logic present, logic last_flag,
                                     output logic [159:0] digest);
    int unsigned pos;
    logic [63:0] bits;
    digest = '0;
    if (present) begin
      pos = bit_total[8:3];
      stash_byte(pos, data);
      bit_total += 64'd8;
      if (pos == 63) run_rounds();
    end
    if (!last_flag) return 1'b0;
    // padding: marker byte, zeros, then the bit length, one or two blocks
    bits = bit_total;
    pos  = bits[8:3];
    stash_byte(pos, PAD_MARK);
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        stash_byte(pos, 8'h00);
        pos++;
      end
      run_rounds();
      pos = 0;
    end
    while (pos < 56) begin
      stash_byte(pos, 8'h00);
      pos++;
    end
    block_buf[14] = bits[63:32];
    block_buf[15] = bits[31:0];
    run_rounds();
    digest = {hash_state[0], hash_state[1], hash_state[2], hash_state[3], hash_state[4]};
    hash_state = IV;
    bit_total  = '0;
    return 1'b1;
  endfunction

  function automatic void queue_digest(logic [159:0] digest);
    digest_word_t due;
    for (int i = 0; i < NUM_WORDS; i++) begin
      due.word      = digest[159 - 32 * i -: 32];
      due.idx       = 3'(i);
      due.last_flag = (3'(i) == IDX_LAST);
      digest_words_due.push_back(due);
    end
  endfunction

  function automatic void check_digest_word();
    digest_word_t due;
    if (digest_words_due.size() == 0) begin
      $error("digest word %h (index %0d) with nothing outstanding", m_tdata, m_tuser);
      mismatches++;
      return;
    end
    due = digest_words_due.pop_front();
    if (m_tdata !== due.word) begin
      $error("digest_word: expected %h, got %h", due.word, m_tdata);
      mismatches++;
    end
    if (m_tuser !== due.idx) begin
      $error("word_index: expected %0d, got %0d", due.idx, m_tuser);
      mismatches++;
    end
    if (m_tlast !== due.last_flag) begin
      $error("digest_last: expected %b, got %b", due.last_flag, m_tlast);
      mismatches++;
    end
  endfunction

  // offers one word after an optional gap and waits for the handshake;
  // valid is only lowered when a gap follows, so it never drops and rises
  // within one step
  task automatic send_word(input logic [7:0] data, input logic present,
                           input logic last_flag, input logic known,
                           input logic [159:0] typed);
    int gap;
    logic [159:0] digest;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= present;
    s_tlast  <= last_flag;
    do @(posedge clk); while (!s_tready);
    if (absorb_word(data, present, last_flag, digest)) queue_digest(known ? typed : digest);
  endtask

  // digest side: checks every accepted word, throttles m_tready, and once
  // holds off for a long stretch so the block backs up onto its input
  initial begin : digest_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_digest_word();
      if (hold > 0) begin
        hold--;
      end else if (hold_off_due && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold = HOLD_OFF_CYCLES;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
      end
      m_tready <= (hold == 0);
    end
  end

  // lengths around the padding boundaries: one block or two, full blocks
  int unsigned pad_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  initial begin : byte_source
    int unsigned sent_bytes;
    int unsigned len;
    logic        end_on_byte;
    hash_state = IV;
    bit_total  = '0;
    foreach (block_buf[i]) block_buf[i] = '0;
    sent_bytes = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_ROWS; i++)
      send_word(script[i].data, script[i].present, script[i].last_flag,
                script[i].known, script[i].digest);

    // random messages: mostly short, some on the padding boundaries, with
    // the odd empty step mixed in
    while (sent_bytes < RAND_BYTES) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 12);
      else len = pad_lens[$urandom_range(0, 7)];
      end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 11) == 0)
          send_word(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        send_word(8'($urandom), 1'b1, end_on_byte && (n == len - 1), 1'b0, '0);
      end
      if (!end_on_byte) send_word(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
      sent_bytes += len;
      // the next message is offered while the sink holds off
      hold_off_due = 1'b1;
    end

    s_tvalid <= 1'b0;
    steady = 1'b0;
    while (digest_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
